/* src/hmpf_pkg.sv */
// ----------------------------------------------------------------------------
// hmpf_pkg: shared types and constants
// Grid sizes, field types and sequencer states for the feasibility core.
// ----------------------------------------------------------------------------
package hmpf_pkg;
  localparam int GRID_X = 8;
  localparam int GRID_Y = 8;
  localparam int CELLS = GRID_X * GRID_Y;
  localparam int HEIGHT_BITS = 6;
  localparam int CELL_W = 6;
  localparam int XW = 3;
  localparam int YW = 3;
  localparam logic [5:0] LIMIT_RESET = 6'd16;
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_PLACE = 1'b1;

  typedef logic [HEIGHT_BITS-1:0] height_t;
  typedef logic [CELL_W-1:0] cell_t;

  typedef struct packed {
    logic func;
    logic [5:0] action_cell;
    logic [3:0] box_len_x;
    logic [3:0] box_len_y;
    logic [5:0] box_len_z;
    logic box_present;
  } req_t;

  typedef struct packed {
    logic [5:0] cell_index;
    logic feasible;
    logic [5:0] base_lvl;
    logic bad_action;
    logic last_cell;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DECIDE,
    ST_WRITE,
    ST_ROWMAX,
    ST_ROWEND,
    ST_COLMAX,
    ST_COLEND,
    ST_RDOUT,
    ST_EMIT,
    ST_ERR
  } state_t;
endpackage

/* src/hmpf_if.sv */
// ----------------------------------------------------------------------------
// hmpf_if: valid/ready channel
// Generic valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface hmpf_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/height_map_placement_feasibility_core.sv */
// ----------------------------------------------------------------------------
// height_map_placement_feasibility_core: bin height map and feasibility
// Places boxes on a height map and rebuilds the per-cell feasibility map.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_     | in  | func, action_cell, box_len_x/y/z, box_present
//  out_    | out | cell_index, feasible, base_lvl, bad_action, last_cell
//  cfg_    | in  | bin_height_limit (6 bits)
// A request spends states CHECK and DECIDE on the lookup, one WRITE step per
// footprint cell when placing, then two window sweeps (ROWMAX, COLMAX) of one
// step per cell plus one per extra window element, each ending in a flush state
// (ROWEND, COLEND), then RDOUT and EMIT per result. A bad placement shows its
// one result in ST_ERR after DECIDE. Results hold while out_ch.ready is low and
// in_ch.ready is high only when idle. Reset starts a clearing pass of 64 cells.
module height_map_placement_feasibility_core (
  input  logic clk,
  input  logic rst_n,
  hmpf_if.sink   in_ch,
  hmpf_if.source out_ch,
  hmpf_if.sink   cfg_ch
);
  import hmpf_pkg::*;

  state_t state_r, state_nxt;
  height_t hgt_mem_r [CELLS];
  height_t rmax_mem_r [CELLS];
  logic [HEIGHT_BITS:0] feas_mem_r [CELLS];
  height_t hgt_q_r, rmax_q_r;
  logic [HEIGHT_BITS:0] feas_q_r;
  logic [3:0] bx_r, by_r;
  logic [5:0] bz_r;
  logic [5:0] limit_r;
  req_t req_r;
  logic [XW-1:0] x_r;
  logic [YW-1:0] y_r;
  logic [2:0] k_r;
  logic [XW-1:0] wx_r;
  logic [YW-1:0] wy_r;
  height_t top_r;
  cell_t e_r;
  logic t_vld_r, t_first_r, t_last_r, t_zero_r;
  cell_t t_cell_r;
  height_t acc_r;

  cell_t cur;
  logic row_ph, walk;
  logic geom_ok, win_ok, last_k;
  logic [3:0] win_len;
  height_t rd, mval;
  logic [HEIGHT_BITS:0] tsum, fsum;
  logic fit;
  logic box_load;
  logic hgt_we, rmax_we, feas_we, feas_re;
  cell_t hgt_waddr, hgt_raddr, rmax_raddr, feas_waddr, feas_raddr;
  height_t hgt_wdata;
  logic [HEIGHT_BITS:0] feas_wdata;

  assign cur = {x_r, y_r};
  assign row_ph = (state_r == ST_ROWMAX) || (state_r == ST_ROWEND);
  assign walk = (state_r == ST_ROWMAX) || (state_r == ST_COLMAX);
  assign geom_ok = bx_r != 4'd0 && by_r != 4'd0 && bx_r <= 4'(GRID_X)
                   && by_r <= 4'(GRID_Y);
  assign win_ok = geom_ok && ({1'b0, y_r} + by_r <= 4'(GRID_Y))
                  && (state_r == ST_ROWMAX || {1'b0, x_r} + bx_r <= 4'(GRID_X));
  assign win_len = (state_r == ST_ROWMAX) ? by_r : bx_r;
  assign last_k = ({1'b0, k_r} == win_len - 4'd1);
  assign hgt_raddr = {x_r, y_r + k_r};
  assign rmax_raddr = {x_r + k_r, y_r};
  assign rd = row_ph ? hgt_q_r : rmax_q_r;
  assign mval = (t_first_r || rd > acc_r) ? rd : acc_r;
  assign fsum = {1'b0, mval} + {1'b0, bz_r};
  assign fit = (fsum <= {1'b0, limit_r});
  assign tsum = {1'b0, feas_q_r[HEIGHT_BITS-1:0]} + {1'b0, bz_r};
  assign box_load = (state_nxt == ST_ROWMAX) && (state_r != ST_ROWMAX);

  always_comb begin
    hgt_we = 1'b0;
    hgt_waddr = cur;
    hgt_wdata = '0;
    rmax_we = row_ph && t_vld_r && t_last_r && !t_zero_r;
    feas_we = 1'b0;
    feas_waddr = t_cell_r;
    feas_wdata = '0;
    feas_re = 1'b0;
    feas_raddr = e_r;
    case (state_r)
      ST_CLEAR: begin
        hgt_we = 1'b1;
        feas_we = 1'b1;
        feas_waddr = cur;
      end
      ST_CHECK: begin
        feas_re = 1'b1;
        feas_raddr = req_r.action_cell;
      end
      ST_WRITE: begin
        hgt_we = 1'b1;
        hgt_waddr = {req_r.action_cell[CELL_W-1:YW] + wx_r,
                     req_r.action_cell[YW-1:0] + wy_r};
        hgt_wdata = top_r;
      end
      ST_COLMAX, ST_COLEND: begin
        feas_we = t_vld_r && (t_zero_r || t_last_r);
        feas_wdata = t_zero_r ? '0 : {fit, mval};
      end
      ST_RDOUT: feas_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hgt_we) hgt_mem_r[hgt_waddr] <= hgt_wdata;
    if (rmax_we) rmax_mem_r[t_cell_r] <= mval;
    if (feas_we) feas_mem_r[feas_waddr] <= feas_wdata;
    hgt_q_r <= hgt_mem_r[hgt_raddr];
    rmax_q_r <= rmax_mem_r[rmax_raddr];
    if (feas_re) feas_q_r <= feas_mem_r[feas_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (cur == '1) state_nxt = ST_IDLE;
      ST_IDLE: if (in_ch.valid) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (req_r.func == FUNC_PLACE) state_nxt = feas_q_r[HEIGHT_BITS] ? ST_WRITE : ST_ERR;
        else state_nxt = ST_ROWMAX;
      end
      ST_WRITE: begin
        if ({1'b0, wx_r} == bx_r - 4'd1 && {1'b0, wy_r} == by_r - 4'd1) state_nxt = ST_ROWMAX;
      end
      ST_ROWMAX: if (cur == '1 && (!win_ok || last_k)) state_nxt = ST_ROWEND;
      ST_ROWEND: state_nxt = ST_COLMAX;
      ST_COLMAX: if (cur == '1 && (!win_ok || last_k)) state_nxt = ST_COLEND;
      ST_COLEND: state_nxt = ST_RDOUT;
      ST_RDOUT: state_nxt = ST_EMIT;
      ST_EMIT: if (out_ch.ready) state_nxt = (e_r == '1) ? ST_IDLE : ST_RDOUT;
      ST_ERR: if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    cfg_ch.ready = 1'b1;
    out_ch.valid = (state_r == ST_EMIT) || (state_r == ST_ERR);
    out_ch.data = '0;
    if (state_r == ST_ERR) begin
      out_ch.data.cell_index = req_r.action_cell;
      out_ch.data.bad_action = 1'b1;
      out_ch.data.last_cell = 1'b1;
    end else begin
      out_ch.data.cell_index = e_r;
      out_ch.data.feasible = feas_q_r[HEIGHT_BITS];
      out_ch.data.base_lvl = feas_q_r[HEIGHT_BITS] ? feas_q_r[HEIGHT_BITS-1:0] : '0;
      out_ch.data.last_cell = (e_r == '1);
    end
  end

  // walkers wrap back to cell 0 at the end of every sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      x_r <= '0;
      y_r <= '0;
      k_r <= '0;
      e_r <= '0;
      t_vld_r <= 1'b0;
      bx_r <= '0;
      by_r <= '0;
      bz_r <= '0;
      limit_r <= LIMIT_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) limit_r <= cfg_ch.data;
      t_vld_r <= walk;
      case (state_r)
        ST_CLEAR: {x_r, y_r} <= cur + 6'd1;
        ST_IDLE: if (in_ch.valid) req_r <= in_ch.data;
        ST_DECIDE: begin
          top_r <= tsum[HEIGHT_BITS] ? '1 : tsum[HEIGHT_BITS-1:0];
          wx_r <= '0;
          wy_r <= '0;
        end
        ST_WRITE: begin
          if ({1'b0, wy_r} == by_r - 4'd1) begin
            wy_r <= '0;
            wx_r <= wx_r + 3'd1;
          end else wy_r <= wy_r + 3'd1;
        end
        ST_ROWMAX, ST_COLMAX: begin
          t_cell_r <= cur;
          t_first_r <= (k_r == '0);
          t_last_r <= last_k;
          t_zero_r <= !win_ok;
          if (win_ok && !last_k) k_r <= k_r + 3'd1;
          else begin
            k_r <= '0;
            {x_r, y_r} <= cur + 6'd1;
          end
        end
        ST_EMIT: if (out_ch.ready) e_r <= e_r + 6'd1;
        default: ;
      endcase
      if (t_vld_r && !t_zero_r && !t_last_r) acc_r <= mval;
      if (box_load) begin
        bx_r <= req_r.box_present ? req_r.box_len_x : '0;
        by_r <= req_r.box_present ? req_r.box_len_y : '0;
        bz_r <= req_r.box_present ? req_r.box_len_z : '0;
      end
    end
  end
endmodule
